/* rtl/core/sbts_pkg.sv */
// Shared types and constants for the snooping bus transaction sequencer.
// No dependencies; imported by sbts_arbiter and the top level.
`default_nettype none

package sbts_pkg;

  // Fixed field widths
  localparam int ADDR_W       = 21;
  localparam int WORD_W       = 32;
  localparam int MASK_W       = 4;
  localparam int CORE_W       = 2;
  localparam int ORIGIN_W     = 3;
  localparam int INDEX_W      = 3;
  localparam int DELAY_W      = 8;
  localparam int MAX_CORES    = 4;

  // Parameter defaults
  localparam int CORE_COUNT_DEFAULT  = 4;
  localparam int BLOCK_WORDS_DEFAULT = 8;

  // Reset values
  localparam logic [DELAY_W-1:0] RESPONSE_DELAY_RESET = 8'd16;
  localparam logic [CORE_W-1:0]  LAST_WINNER_RESET    = 2'd3;

  // Origin code for data supplied by memory
  localparam logic [ORIGIN_W-1:0] ORIGIN_MEMORY = 3'd4;

  // Bus command codes
  typedef enum logic [1:0] {
    CMD_NONE   = 2'd0,
    CMD_BUSRD  = 2'd1,
    CMD_BUSRDX = 2'd2,
    CMD_FLUSH  = 2'd3
  } cmd_t;

  // Final MESI state of the requester's line
  typedef enum logic [1:0] {
    LINE_SHARED    = 2'd0,
    LINE_EXCLUSIVE = 2'd1,
    LINE_MODIFIED  = 2'd2
  } mesi_t;

  // Arbiter decision
  typedef struct packed {
    logic              found;
    logic [CORE_W-1:0] core;
  } grant_t;

  // One bus cycle worth of outputs
  typedef struct packed {
    cmd_t                command;
    logic [ORIGIN_W-1:0] origin;
    logic [ADDR_W-1:0]   address;
    logic [WORD_W-1:0]   word;
    logic                shared_line;
    logic                memory_write;
    logic [CORE_W-1:0]   fill_core;
    logic [INDEX_W-1:0]  fill_index;
    logic                done;
    mesi_t               final_state;
  } result_t;

endpackage

`default_nettype wire

/* rtl/core/snoop_bus_transaction_sequencer.sv */
// Snooping bus transaction sequencer, top level.
// Depends on sbts_pkg and sbts_arbiter.
//
// Each accepted transaction is one bus clock and yields exactly one result
// transaction, registered in the output queue. A new transaction is accepted every cycle
// while the result side keeps taking results; a two-entry output queue
// (result register plus skid register) lets one more transaction in while a
// result waits, and item_stall rises only when that skid register is full.
// A bus transaction spans these input cycles, in order:
// the BusRd/BusRdX command cycle, the idle delay cycles, then the Flush
// words. Requests are only looked at while the bus is idle. The
// configuration port is always ready and should be written while idle.
`default_nettype none

module snoop_bus_transaction_sequencer
  import sbts_pkg::*;
#(
  parameter int CORE_COUNT  = CORE_COUNT_DEFAULT,
  parameter int BLOCK_WORDS = BLOCK_WORDS_DEFAULT
) (
  input  wire logic                clk,
  input  wire logic                rst,

  // Configuration write channel
  input  wire logic                cfg_valid,
  output      logic                cfg_ready,
  input  wire logic [DELAY_W-1:0]  cfg_data,

  // Input transaction channel
  input  wire logic                item_valid,
  output      logic                item_stall,
  input  wire logic [MASK_W-1:0]   request_mask,
  input  wire logic [MASK_W-1:0]   rdx_mask,
  input  wire logic [ADDR_W-1:0]   addr_core0,
  input  wire logic [ADDR_W-1:0]   addr_core1,
  input  wire logic [ADDR_W-1:0]   addr_core2,
  input  wire logic [ADDR_W-1:0]   addr_core3,
  input  wire logic                shared_hit,
  input  wire logic                snoop_owner_valid,
  input  wire logic [CORE_W-1:0]   snoop_owner,
  input  wire logic [WORD_W-1:0]   flush_data,

  // Result transaction channel
  output      logic                result_valid,
  input  wire logic                result_stall,
  output      logic [1:0]          bus_command,
  output      logic [ORIGIN_W-1:0] bus_origin,
  output      logic [ADDR_W-1:0]   bus_address,
  output      logic [WORD_W-1:0]   bus_word,
  output      logic                bus_shared_line,
  output      logic                memory_write,
  output      logic [CORE_W-1:0]   fill_core,
  output      logic [INDEX_W-1:0]  fill_index,
  output      logic                done_res,
  output      logic [1:0]          final_state
);

  localparam int WC_W = $clog2(BLOCK_WORDS + 1);
  localparam logic [WC_W-1:0] LAST_COUNT = WC_W'(BLOCK_WORDS);
  localparam logic [CORE_W:0] COUNT      = (CORE_W+1)'(CORE_COUNT);

  // Configuration and sequencer state
  logic [DELAY_W-1:0] response_delay;
  logic [CORE_W-1:0]  last_winner;
  logic               busy;
  logic [DELAY_W-1:0] delay_left;
  logic [WC_W-1:0]    words_done;
  logic [CORE_W-1:0]  requester;
  logic [ADDR_W-1:0]  base_address;
  logic               exclusive_read;
  logic               owner_present;
  logic [CORE_W-1:0]  owner_core;
  logic               held_shared;

  logic [CORE_W-1:0]  last_winner_next;
  logic               busy_next;
  logic [DELAY_W-1:0] delay_left_next;
  logic [WC_W-1:0]    words_done_next;
  logic [CORE_W-1:0]  requester_next;
  logic [ADDR_W-1:0]  base_address_next;
  logic               exclusive_read_next;
  logic               owner_present_next;
  logic [CORE_W-1:0]  owner_core_next;
  logic               held_shared_next;

  // Output queue
  result_t            result_q;
  result_t            skid_q;
  logic               skid_valid;
  result_t            step_result;

  logic               accept;
  logic               pop;
  grant_t             grant;
  logic [ADDR_W-1:0]  grant_addr;
  logic               grant_rdx;
  logic               grant_owner;
  logic [WC_W-1:0]    words_inc;

  assign cfg_ready  = 1'b1;
  assign item_stall = skid_valid;
  assign accept     = item_valid && !item_stall;
  assign pop        = result_valid && !result_stall;

  sbts_arbiter #(
    .CORE_COUNT (CORE_COUNT)
  ) u_arbiter (
    .request_mask (request_mask),
    .last_winner  (last_winner),
    .grant        (grant)
  );

  // Select the winner's address and read type
  always_comb begin
    case (grant.core)
      2'd0:    grant_addr = addr_core0;
      2'd1:    grant_addr = addr_core1;
      2'd2:    grant_addr = addr_core2;
      default: grant_addr = addr_core3;
    endcase
  end

  assign grant_rdx   = rdx_mask[grant.core];
  assign grant_owner = snoop_owner_valid && ({1'b0, snoop_owner} < COUNT);
  assign words_inc   = words_done + WC_W'(1);

  // Step the sequencer for one bus cycle
  always_comb begin
    last_winner_next    = last_winner;
    busy_next           = busy;
    delay_left_next     = delay_left;
    words_done_next     = words_done;
    requester_next      = requester;
    base_address_next   = base_address;
    exclusive_read_next = exclusive_read;
    owner_present_next  = owner_present;
    owner_core_next     = owner_core;
    held_shared_next    = held_shared;
    step_result         = '0;

    if (busy) begin
      if (delay_left != '0) begin
        delay_left_next = delay_left - DELAY_W'(1);
      end else begin
        step_result.command      = CMD_FLUSH;
        step_result.origin       = owner_present ? {1'b0, owner_core} : ORIGIN_MEMORY;
        step_result.address      = base_address + ADDR_W'(words_done);
        step_result.word         = flush_data;
        step_result.shared_line  = held_shared;
        step_result.memory_write = owner_present;
        step_result.fill_core    = requester;
        step_result.fill_index   = INDEX_W'(words_done);
        words_done_next          = words_inc;
        if (words_inc >= LAST_COUNT) begin
          step_result.done = 1'b1;
          if (exclusive_read) begin
            step_result.final_state = LINE_MODIFIED;
          end else if (held_shared) begin
            step_result.final_state = LINE_SHARED;
          end else begin
            step_result.final_state = LINE_EXCLUSIVE;
          end
          busy_next = 1'b0;
        end
      end
    end else if (grant.found) begin
      requester_next      = grant.core;
      base_address_next   = grant_addr;
      exclusive_read_next = grant_rdx;
      held_shared_next    = shared_hit;
      owner_present_next  = grant_owner;
      owner_core_next     = grant_owner ? snoop_owner : '0;
      last_winner_next    = grant.core;
      busy_next           = 1'b1;
      delay_left_next     = response_delay;
      words_done_next     = '0;
      step_result.command     = grant_rdx ? CMD_BUSRDX : CMD_BUSRD;
      step_result.origin      = {1'b0, grant.core};
      step_result.address     = grant_addr;
      step_result.shared_line = shared_hit;
    end
  end

  // Hold configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      response_delay <= RESPONSE_DELAY_RESET;
    end else if (cfg_valid && cfg_ready) begin
      response_delay <= cfg_data;
    end
  end

  // Advance sequencer state on each accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      last_winner    <= LAST_WINNER_RESET;
      busy           <= 1'b0;
      delay_left     <= '0;
      words_done     <= '0;
      requester      <= '0;
      base_address   <= '0;
      exclusive_read <= 1'b0;
      owner_present  <= 1'b0;
      owner_core     <= '0;
      held_shared    <= 1'b0;
    end else if (accept) begin
      last_winner    <= last_winner_next;
      busy           <= busy_next;
      delay_left     <= delay_left_next;
      words_done     <= words_done_next;
      requester      <= requester_next;
      base_address   <= base_address_next;
      exclusive_read <= exclusive_read_next;
      owner_present  <= owner_present_next;
      owner_core     <= owner_core_next;
      held_shared    <= held_shared_next;
    end
  end

  // Output queue control: result register first, skid register behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (pop || !result_valid) begin
      if (skid_valid) begin
        result_valid <= 1'b1;
        skid_valid   <= accept;
      end else begin
        result_valid <= accept;
        skid_valid   <= 1'b0;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  // Output queue payload
  always_ff @(posedge clk) begin
    if (pop || !result_valid) begin
      if (skid_valid) begin
        result_q <= skid_q;
        skid_q   <= step_result;
      end else begin
        result_q <= step_result;
      end
    end else if (accept) begin
      skid_q <= step_result;
    end
  end

  // Drive result ports
  assign bus_command     = result_q.command;
  assign bus_origin      = result_q.origin;
  assign bus_address     = result_q.address;
  assign bus_word        = result_q.word;
  assign bus_shared_line = result_q.shared_line;
  assign memory_write    = result_q.memory_write;
  assign fill_core       = result_q.fill_core;
  assign fill_index      = result_q.fill_index;
  assign done_res        = result_q.done;
  assign final_state     = result_q.final_state;

endmodule

`default_nettype wire

/* rtl/core/sbts_arbiter.sv */
// Round-robin arbiter: first requesting core after the last winner.
// Depends on sbts_pkg for grant_t and field widths.
`default_nettype none

module sbts_arbiter
  import sbts_pkg::*;
#(
  parameter int CORE_COUNT = CORE_COUNT_DEFAULT
) (
  input  wire logic [MASK_W-1:0] request_mask,
  input  wire logic [CORE_W-1:0] last_winner,
  output grant_t                 grant
);

  localparam logic [CORE_W:0] COUNT = (CORE_W+1)'(CORE_COUNT);

  // Wrap a small candidate index back into the core range
  function automatic logic [CORE_W-1:0] wrap_core(input logic [CORE_W:0] v);
    logic [CORE_W:0] t;
    t = v;
    if (t >= COUNT) t = t - COUNT;
    if (t >= COUNT) t = t - COUNT;
    return t[CORE_W-1:0];
  endfunction

  // Scan cores in priority order, take the first request
  always_comb begin
    logic [CORE_W-1:0] c;
    grant = '0;
    for (int i = 0; i < CORE_COUNT; i++) begin
      c = wrap_core({1'b0, last_winner} + (CORE_W+1)'(1) + (CORE_W+1)'(i));
      if (!grant.found && request_mask[c]) begin
        grant.found = 1'b1;
        grant.core  = c;
      end
    end
  end

endmodule

`default_nettype wire
